// File: sv/asv_pkg.sv
// asv_pkg: shared types and constants for the ascending sort engine.
// Used by asv_cell and ascending_sort_engine; no dependencies.
package asv_pkg;

	localparam int CAPACITY = 64;
	localparam int VALUE_W  = 31;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CNT_W-1:0]   count_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		value_t   value;
		count_t   count;
	} cell_ctl_t;

endpackage

// File: sv/asv_cell.sv
// asv_cell: one slot of the insertion chain; holds one value in sorted order.
// Depends on asv_pkg.
module asv_cell (
	input  logic              clk,
	input  asv_pkg::cell_ctl_t ctl,
	input  asv_pkg::count_t   cell_idx,
	input  asv_pkg::value_t   left_value,
	input  logic              left_gt,
	input  asv_pkg::value_t   right_value,
	output asv_pkg::value_t   value_q,
	output logic              gt
);
	import asv_pkg::*;

	logic occupied;

	// slot is "greater" when empty or holding a value above the incoming one
	assign occupied = (cell_idx < ctl.count);
	assign gt       = !occupied || (value_q > ctl.value);

	// insert: keep, take the new value, or take the left neighbor's; drain: shift left
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_INSERT: begin
				if (gt) begin
					value_q <= left_gt ? left_value : ctl.value;
				end
			end
			OP_SHIFT:  value_q <= right_value;
			OP_HOLD:   value_q <= value_q;
			default:   value_q <= value_q;
		endcase
	end

endmodule

// File: sv/ascending_sort_engine.sv
// ascending_sort_engine: top level; insertion chain of asv_cell slots plus control.
// Depends on asv_pkg and asv_cell.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, value, final_item     | into block
//  out     | out_valid, out_ready, sorted_value,       | out of block
//          | last_of_run, status                       |
//
// Fill: one input transfer per cycle; every cell compares against the new value
// in parallel and the chain shifts right by one slot above the insertion point.
// Drain: one result per cycle from slot 0 while the chain shifts left, as long
// as out_ready is high; an error result is a single transfer. No input is taken
// during a drain. Reset empties the chain; out_ready low simply holds the drain.
module ascending_sort_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [30:0]         value,
	input  logic                final_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [30:0]         sorted_value,
	output logic                last_of_run,
	output logic [1:0]          status
);
	import asv_pkg::*;

	typedef enum logic [1:0] {
		S_FILL,
		S_DRAIN,
		S_ERR
	} state_t;

	state_t    state_q;
	count_t    count_q;
	logic      ovf_q;
	status_t   err_q;

	logic      in_fire;
	logic      out_fire;
	logic      full;
	logic      do_ins;
	logic      ovf_next;
	count_t    cnt_after;
	cell_ctl_t ctl;

	value_t              cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_gt;

	assign in_ready  = (state_q == S_FILL);
	assign out_valid = (state_q == S_DRAIN) || (state_q == S_ERR);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// capacity tracking
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign do_ins    = in_fire && !ovf_q && !full;
	assign ovf_next  = ovf_q || (in_fire && full);
	assign cnt_after = count_q + CNT_W'(do_ins);

	// chain command
	always_comb begin
		ctl.value = value;
		ctl.count = count_q;
		if (do_ins) begin
			ctl.op = OP_INSERT;
		end else if ((state_q == S_DRAIN) && out_fire) begin
			ctl.op = OP_SHIFT;
		end else begin
			ctl.op = OP_HOLD;
		end
	end

	// the chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		value_t lv;
		logic   lg;
		value_t rv;
		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_value[i-1];
			assign lg = cell_gt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = '0;
		end else begin : g_inner
			assign rv = cell_value[i+1];
		end
		asv_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.cell_idx    (CNT_W'(i)),
			.left_value  (lv),
			.left_gt     (lg),
			.right_value (rv),
			.value_q     (cell_value[i]),
			.gt          (cell_gt[i])
		);
	end

	// control: fill, drain, single error result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			count_q <= '0;
			ovf_q   <= 1'b0;
			err_q   <= ST_OK;
		end else begin
			unique case (state_q)
				S_FILL: begin
					if (in_fire) begin
						if (final_item) begin
							ovf_q <= 1'b0;
							if (ovf_next) begin
								state_q <= S_ERR;
								err_q   <= ST_OVERFLOW;
								count_q <= '0;
							end else if (cnt_after < CNT_W'(2)) begin
								state_q <= S_ERR;
								err_q   <= ST_SHORT;
								count_q <= '0;
							end else begin
								state_q <= S_DRAIN;
								count_q <= cnt_after;
							end
						end else begin
							ovf_q   <= ovf_next;
							count_q <= cnt_after;
						end
					end
				end
				S_DRAIN: begin
					if (out_fire) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q <= S_FILL;
						end
					end
				end
				S_ERR: begin
					if (out_fire) begin
						state_q <= S_FILL;
					end
				end
				default: state_q <= S_FILL;
			endcase
		end
	end

	// result fields
	assign sorted_value = (state_q == S_ERR) ? '0 : cell_value[0];
	assign last_of_run  = (state_q == S_ERR) || (count_q == CNT_W'(1));
	assign status       = (state_q == S_ERR) ? err_q : ST_OK;

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open at once");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (count_q >= CNT_W'(1)))
		else $error("drain with empty chain");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_final_leaves_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && final_item) |=> (state_q != S_FILL))
		else $error("final transfer gave no result");

	a_err_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERR) |-> ((err_q == ST_SHORT) || (err_q == ST_OVERFLOW)))
		else $error("error result without error code");

endmodule

// File: tb/ascending_sort_engine_test.sv
// ascending_sort_engine_test: self-checking testbench for the ascending sort engine.
// Depends on asv_pkg and the ascending_sort_engine RTL; tracks the sorted run in
// its own queue model and checks every result transfer against it.
module ascending_sort_engine_test;
	import asv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CYCLE_LIMIT = 200000;
	localparam int     RANDOM_ITEMS = 40;
	localparam value_t VALUE_MAX = {VALUE_W{1'b1}};

	// one expected result transfer
	typedef struct {
		value_t  value;
		logic    last;
		status_t status;
	} run_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	value_t     value = '0;
	logic       final_item = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	value_t     sorted_value;
	logic       last_of_run;
	logic [1:0] status;

	// model state: ascending values of the current sequence plus overflow flag
	value_t      held_values[$];
	logic        overflow_seen = 1'b0;
	run_result_t expected_results[$];

	int  err_count = 0;
	int  cycle_count = 0;
	int  random_sent = 0;
	bit  quiet_phase = 1'b0;

	ascending_sort_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.final_item  (final_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sorted_value(sorted_value),
		.last_of_run (last_of_run),
		.status      (status)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver back-pressure, off during quiet phases
	always @(posedge clk) begin
		if (quiet_phase)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 12);
	end

	// append one expected result at the tail of the queue
	task automatic add_expected(input run_result_t res);
		expected_results.insert(expected_results.size(), res);
	endtask

	// update the model with one accepted value; queue results on the final one
	task automatic predict_sorted(input value_t v, input logic fin);
		int          pos;
		run_result_t res;
		if (overflow_seen || held_values.size() >= CAPACITY) begin
			overflow_seen = 1'b1;
		end else begin
			// equal values already held stay ahead of the new one
			pos = 0;
			while (pos < held_values.size() && held_values[pos] <= v)
				pos++;
			held_values.insert(pos, v);
		end
		if (fin) begin
			if (overflow_seen) begin
				res = '{value: '0, last: 1'b1, status: ST_OVERFLOW};
				add_expected(res);
			end else if (held_values.size() < 2) begin
				res = '{value: '0, last: 1'b1, status: ST_SHORT};
				add_expected(res);
			end else begin
				foreach (held_values[i]) begin
					res.value  = held_values[i];
					res.last   = (i == held_values.size() - 1);
					res.status = ST_OK;
					add_expected(res);
				end
			end
			held_values.delete();
			overflow_seen = 1'b0;
		end
	endtask

	// offer one item, with an occasional gap first, and wait for its transfer
	task automatic send_item(input value_t v, input logic fin);
		int gap;
		gap = (!quiet_phase && $urandom_range(99) < 5) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		value      <= v;
		final_item <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		predict_sorted(v, fin);
	endtask

	function automatic value_t pick_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return VALUE_MAX;
			2, 3:    return value_t'($urandom_range(7));
			default: return value_t'($urandom);
		endcase
	endfunction

	// sequence of n random values, final flag on the last
	task automatic send_sequence(input int n);
		for (int i = 0; i < n; i++)
			send_item(pick_value(), i == n - 1);
	endtask

	// result checker
	always @(posedge clk) begin
		run_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: sorted_value=%0d last_of_run=%0b status=%0d",
					sorted_value, last_of_run, status);
				err_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (sorted_value !== exp_res.value) begin
					$error("sorted_value: expected %0d, actual %0d", exp_res.value,
						sorted_value);
					err_count++;
				end
				if (last_of_run !== exp_res.last) begin
					$error("last_of_run: expected %0b, actual %0b", exp_res.last,
						last_of_run);
					err_count++;
				end
				if (status !== exp_res.status) begin
					$error("status: expected %0d, actual %0d", exp_res.status, status);
					err_count++;
				end
			end
		end
	end

	// sequences with fewer than two values
	task automatic test_short_runs();
		send_item('0, 1'b1);
		send_item(VALUE_MAX, 1'b1);
	endtask

	// field extremes in two-value runs
	task automatic test_extremes();
		send_item(VALUE_MAX, 1'b0);
		send_item('0, 1'b1);
		send_item('0, 1'b0);
		send_item(VALUE_MAX, 1'b1);
		send_item(VALUE_MAX, 1'b0);
		send_item(VALUE_MAX, 1'b1);
	endtask

	// equal values are all kept
	task automatic test_duplicates();
		send_item(value_t'(5), 1'b0);
		send_item(value_t'(3), 1'b0);
		send_item(value_t'(5), 1'b0);
		send_item(value_t'(3), 1'b0);
		send_item(value_t'(5), 1'b1);
	endtask

	// strictly descending input, alternating bit patterns included
	task automatic test_descending();
		send_item(VALUE_MAX, 1'b0);
		send_item(value_t'(31'h5555_5555), 1'b0);
		send_item(value_t'(31'h2AAA_AAAA), 1'b0);
		send_item(value_t'(1000), 1'b0);
		send_item(value_t'(1), 1'b0);
		send_item('0, 1'b1);
	endtask

	// store filled to the last slot, one value over, then a normal run right after
	task automatic test_capacity();
		quiet_phase = 1'b1;
		send_sequence(CAPACITY + 1);
		quiet_phase = 1'b0;
		send_sequence(3);
	endtask

	// random sequences, mostly short, some with a single value
	task automatic test_random_runs();
		int n;
		while (random_sent < RANDOM_ITEMS) begin
			// a stretch with no idling on either side in the middle
			quiet_phase = (random_sent >= 12 && random_sent < 28);
			n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
			send_sequence(n);
			random_sent += n;
		end
		quiet_phase = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_short_runs();
		test_extremes();
		test_duplicates();
		test_descending();
		test_capacity();
		test_random_runs();

		@(posedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("results still expected at end: %0d", expected_results.size());
			err_count++;
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
